>>> sv/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants for the clamped PID controller: register map,
// configuration bundle, multiply-add operation and sequencer states.
// ----------------------------------------------------------------------------
package pidc_pkg;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_TIME_STEP,
		REG_SETPOINT,
		REG_OUT_MIN,
		REG_OUT_MAX
	} reg_idx_t;

	localparam logic [15:0] GAIN_P_RST    = 16'd128;
	localparam logic [15:0] GAIN_I_RST    = 16'd51;
	localparam logic [15:0] GAIN_D_RST    = 16'd0;
	localparam logic [15:0] TIME_STEP_RST = 16'd655;
	localparam logic [15:0] SETPOINT_RST  = 16'd0;
	localparam logic [31:0] OUT_MIN_RST   = 32'h8000_0000;
	localparam logic [31:0] OUT_MAX_RST   = 32'h7FFF_FFFF;

	localparam logic [5:0] DIV_LAST = 6'd41;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [15:0] time_step;
		logic [15:0] setpoint;
		logic [31:0] out_min;
		logic [31:0] out_max;
	} cfg_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_22,
		SH_24
	} sh_t;

	typedef struct packed {
		logic [63:0] addend;
		logic [17:0] a;
		logic [25:0] b;
		sh_t         sh;
	} mac_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_INT,
		ST_DIFF,
		ST_DIV,
		ST_I_LO,
		ST_I_HI,
		ST_D_LO,
		ST_D_HI,
		ST_P,
		ST_CLMIN,
		ST_CLMAX
	} state_t;

endpackage

>>> sv/pid_controller_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Fixed-point PID controller with output clamp, built around one shared
// multiply-add unit stepped by a sequencer.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+-------------------
//   sample    | in        | sample_valid/sample_stall | sample  Q8.8
//   drive     | out       | drive_valid/drive_stall   | drive   Q16.16
//   config    | in        | wr_en                     | wr_index, wr_data
//
// When the time step is nonzero the derivative is found by a bit-serial
// divide; when it is zero the divide is skipped. The multiply-add unit is
// the single multiplier; the clamp compares lie outside it.
// Reset clears the integral and previous error and loads default gains.
// The block takes a new sample only while its sequencer is idle; a result
// waiting on drive_stall holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [15:0] sample,
	output logic        drive_valid,
	input  logic        drive_stall,
	output logic [31:0] drive
);

	pidc_pkg::cfg_t    cfg;
	pidc_pkg::mac_op_t mac_op;
	logic [63:0]       mac_res;

	pidc_pkg::state_t state_q, state_d;

	logic [15:0] sample_q;
	logic [16:0] err_q;
	logic [47:0] error_sum_q;
	logic [16:0] last_error_q;
	logic        neg_q;
	logic [41:0] dvd_q;
	logic [15:0] rem_q;
	logic [41:0] quo_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [31:0] drive_q;
	logic        drive_valid_q;

	logic [16:0] gd_x;
	logic [16:0] gd_s;
	logic [17:0] diff;
	logic [17:0] mag;
	logic        advance_out;

	pidc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pidc_mac u_mac (
		.op  (mac_op),
		.res (mac_res)
	);

	assign sample_stall = (state_q != pidc_pkg::ST_IDLE);
	assign advance_out  = !drive_valid_q || !drive_stall;

	assign gd_x = {cfg.gain_d[15], cfg.gain_d};
	assign gd_s = neg_q ? 17'(-gd_x) : gd_x;
	assign diff = mac_res[17:0];
	assign mag  = diff[17] ? 18'(-diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mac_op.addend = 64'd0;
		mac_op.a      = 18'd0;
		mac_op.b      = 26'd0;
		mac_op.sh     = pidc_pkg::SH_0;
		case (state_q)
			pidc_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = pidc_pkg::ST_ERR;
				end
			end
			pidc_pkg::ST_ERR: begin
				mac_op.addend = {{48{cfg.setpoint[15]}}, cfg.setpoint};
				mac_op.a      = '1;
				mac_op.b      = {{10{sample_q[15]}}, sample_q};
				state_d       = pidc_pkg::ST_INT;
			end
			pidc_pkg::ST_INT: begin
				mac_op.addend = {{16{error_sum_q[47]}}, error_sum_q};
				mac_op.a      = {err_q[16], err_q};
				mac_op.b      = {10'd0, cfg.time_step};
				state_d       = pidc_pkg::ST_DIFF;
			end
			pidc_pkg::ST_DIFF: begin
				mac_op.addend = {{47{err_q[16]}}, err_q};
				mac_op.a      = '1;
				mac_op.b      = {{9{last_error_q[16]}}, last_error_q};
				state_d       = (cfg.time_step == 16'd0) ? pidc_pkg::ST_I_LO
				                                         : pidc_pkg::ST_DIV;
			end
			pidc_pkg::ST_DIV: begin
				mac_op.addend = {47'd0, rem_q, dvd_q[41]};
				mac_op.a      = '1;
				mac_op.b      = {10'd0, cfg.time_step};
				if (cnt_q == pidc_pkg::DIV_LAST) begin
					state_d = pidc_pkg::ST_I_LO;
				end
			end
			pidc_pkg::ST_I_LO: begin
				mac_op.a = {{2{cfg.gain_i[15]}}, cfg.gain_i};
				mac_op.b = {2'd0, error_sum_q[23:0]};
				state_d  = pidc_pkg::ST_I_HI;
			end
			pidc_pkg::ST_I_HI: begin
				mac_op.addend = acc_q;
				mac_op.a      = {{2{cfg.gain_i[15]}}, cfg.gain_i};
				mac_op.b      = {{2{error_sum_q[47]}}, error_sum_q[47:24]};
				mac_op.sh     = pidc_pkg::SH_24;
				state_d       = pidc_pkg::ST_D_LO;
			end
			pidc_pkg::ST_D_LO: begin
				mac_op.addend = {{8{acc_q[63]}}, acc_q[63:16], 8'd0};
				mac_op.a      = {gd_s[16], gd_s};
				mac_op.b      = {4'd0, quo_q[21:0]};
				state_d       = pidc_pkg::ST_D_HI;
			end
			pidc_pkg::ST_D_HI: begin
				mac_op.addend = acc_q;
				mac_op.a      = {gd_s[16], gd_s};
				mac_op.b      = {6'd0, quo_q[41:22]};
				mac_op.sh     = pidc_pkg::SH_22;
				state_d       = pidc_pkg::ST_P;
			end
			pidc_pkg::ST_P: begin
				mac_op.addend = {{8{acc_q[63]}}, acc_q[63:8]};
				mac_op.a      = {err_q[16], err_q};
				mac_op.b      = {{10{cfg.gain_p[15]}}, cfg.gain_p};
				state_d       = pidc_pkg::ST_CLMIN;
			end
			pidc_pkg::ST_CLMIN: begin
				state_d = pidc_pkg::ST_CLMAX;
			end
			pidc_pkg::ST_CLMAX: begin
				if (advance_out) begin
					state_d = pidc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pidc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				pidc_pkg::ST_INT: begin
					if (mac_res[63:47] == {17{mac_res[47]}}) begin
						error_sum_q <= mac_res[47:0];
					end else begin
						error_sum_q <= mac_res[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
					end
				end
				pidc_pkg::ST_DIFF: begin
					last_error_q <= err_q;
					cnt_q        <= '0;
				end
				pidc_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pidc_pkg::ST_IDLE: begin
				sample_q <= sample;
			end
			pidc_pkg::ST_ERR: begin
				err_q <= mac_res[16:0];
			end
			pidc_pkg::ST_DIFF: begin
				neg_q <= diff[17];
				dvd_q <= {mag, 24'd0};
				rem_q <= '0;
				quo_q <= '0;
			end
			pidc_pkg::ST_DIV: begin
				dvd_q <= {dvd_q[40:0], 1'b0};
				if (!mac_res[63]) begin
					rem_q <= mac_res[15:0];
					quo_q <= {quo_q[40:0], 1'b1};
				end else begin
					rem_q <= {rem_q[14:0], dvd_q[41]};
					quo_q <= {quo_q[40:0], 1'b0};
				end
			end
			pidc_pkg::ST_I_LO, pidc_pkg::ST_I_HI, pidc_pkg::ST_D_LO,
			pidc_pkg::ST_D_HI, pidc_pkg::ST_P: begin
				acc_q <= mac_res;
			end
			pidc_pkg::ST_CLMIN: begin
				if ($signed(acc_q) < $signed({{32{cfg.out_min[31]}}, cfg.out_min})) begin
					acc_q <= {{32{cfg.out_min[31]}}, cfg.out_min};
				end
			end
			pidc_pkg::ST_CLMAX: begin
				if (advance_out) begin
					if ($signed(acc_q) > $signed({{32{cfg.out_max[31]}}, cfg.out_max})) begin
						drive_q <= cfg.out_max;
					end else begin
						drive_q <= acc_q[31:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (state_q == pidc_pkg::ST_CLMAX && advance_out) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> state_q == pidc_pkg::ST_ERR)
		else $error("sample transfer did not start the sequencer");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pidc_pkg::ST_DIV |-> cnt_q <= pidc_pkg::DIV_LAST)
		else $error("divide step count overran");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pidc_pkg::ST_DIV |-> rem_q < cfg.time_step)
		else $error("divide remainder not below time step");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_valid_q) |-> $past(state_q) == pidc_pkg::ST_CLMAX)
		else $error("result raised outside the clamp step");

endmodule

>>> sv/pidc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_cfg
// Configuration register file: gains, time step, setpoint and output limits.
// ----------------------------------------------------------------------------
module pidc_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [31:0]      wr_data,
	output pidc_pkg::cfg_t   cfg
);

	pidc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p    <= pidc_pkg::GAIN_P_RST;
			cfg_q.gain_i    <= pidc_pkg::GAIN_I_RST;
			cfg_q.gain_d    <= pidc_pkg::GAIN_D_RST;
			cfg_q.time_step <= pidc_pkg::TIME_STEP_RST;
			cfg_q.setpoint  <= pidc_pkg::SETPOINT_RST;
			cfg_q.out_min   <= pidc_pkg::OUT_MIN_RST;
			cfg_q.out_max   <= pidc_pkg::OUT_MAX_RST;
		end else if (wr_en) begin
			case (pidc_pkg::reg_idx_t'(wr_index))
				pidc_pkg::REG_GAIN_P:    cfg_q.gain_p    <= wr_data[15:0];
				pidc_pkg::REG_GAIN_I:    cfg_q.gain_i    <= wr_data[15:0];
				pidc_pkg::REG_GAIN_D:    cfg_q.gain_d    <= wr_data[15:0];
				pidc_pkg::REG_TIME_STEP: cfg_q.time_step <= wr_data[15:0];
				pidc_pkg::REG_SETPOINT:  cfg_q.setpoint  <= wr_data[15:0];
				pidc_pkg::REG_OUT_MIN:   cfg_q.out_min   <= wr_data;
				pidc_pkg::REG_OUT_MAX:   cfg_q.out_max   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/pidc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mac
// Shared multiply-add unit: addend + (a * b) << shift, signed, 64-bit result.
// ----------------------------------------------------------------------------
module pidc_mac (
	input  pidc_pkg::mac_op_t op,
	output logic [63:0]       res
);

	logic signed [43:0] prod;
	logic        [63:0] prod_ext;
	logic        [63:0] prod_sh;

	assign prod     = $signed(op.a) * $signed(op.b);
	assign prod_ext = {{20{prod[43]}}, prod};

	always_comb begin
		case (op.sh)
			pidc_pkg::SH_0:  prod_sh = prod_ext;
			pidc_pkg::SH_22: prod_sh = {prod_ext[41:0], 22'b0};
			pidc_pkg::SH_24: prod_sh = {prod_ext[39:0], 24'b0};
			default:         prod_sh = prod_ext;
		endcase
	end

	assign res = op.addend + prod_sh;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for pid_controller_clamped
// Drives measured samples and register writes into the controller and checks
// every drive value against an in-bench fixed-point PID predictor or a table
// value. A short table covers reset values, field extremes, zero and tiny time
// steps, coincident and inverted limits and an unmapped register index. Random
// phases reprogram all registers and stream samples, with random gaps and stalls
// in most phases, and a windup run pushes the integral hard one way and then
// reverses the error. A watchdog ends the run when nothing transfers for too long.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         QUIET_LIMIT  = 3000;
	localparam longint     INTEG_MAX    = (longint'(1) <<< 47) - 1;
	localparam longint     INTEG_MIN    = -(longint'(1) <<< 47);

	typedef enum bit {DO_WRITE, DO_SAMPLE} act_t;

	typedef struct {
		act_t        act;
		logic [2:0]  idx;
		logic [31:0] val;
		bit          typed;
		logic [31:0] want;
	} step_t;

	localparam int N_STEPS = 33;

	// index is ignored on sample rows
	step_t plan [N_STEPS] = '{
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_0000, 1'b1, 32'h0000_0000},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_7FFF, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_8000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_0100, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_GAIN_D,    32'h0000_7FFF, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_8000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_7FFF, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_TIME_STEP, 32'h0000_0000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_1234, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_8000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_TIME_STEP, 32'h0000_FFFF, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_GAIN_P,    32'h0000_8000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_GAIN_I,    32'h0000_8000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_GAIN_D,    32'h0000_8000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_7FFF, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_8000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_SETPOINT,  32'h0000_7FFF, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_8000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_SETPOINT,  32'h0000_8000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_7FFF, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_OUT_MIN,   32'h0000_1000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_OUT_MAX,   32'h0000_1000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_0000, 1'b1, 32'h0000_1000},
		'{DO_WRITE,  pidc_pkg::REG_OUT_MAX,   32'hFFFF_F000, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_1234, 1'b1, 32'hFFFF_F000},
		'{DO_WRITE,  REG_UNMAPPED,            32'hFFFF_FFFF, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_0000, 1'b1, 32'hFFFF_F000},
		'{DO_WRITE,  pidc_pkg::REG_OUT_MIN,   32'h8000_0000, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_OUT_MAX,   32'h7FFF_FFFF, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_GAIN_P,    32'hABCD_0080, 1'b0, 32'h0},
		'{DO_WRITE,  pidc_pkg::REG_TIME_STEP, 32'h1234_0001, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_00FF, 1'b0, 32'h0},
		'{DO_SAMPLE, REG_UNMAPPED,            32'h0000_FF00, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;
	logic        sample_valid;
	logic        sample_stall;
	logic [15:0] sample;
	logic        drive_valid;
	logic        drive_stall;
	logic [31:0] drive;

	pidc_pkg::cfg_t ctl_cfg = '{pidc_pkg::GAIN_P_RST, pidc_pkg::GAIN_I_RST,
		pidc_pkg::GAIN_D_RST, pidc_pkg::TIME_STEP_RST, pidc_pkg::SETPOINT_RST,
		pidc_pkg::OUT_MIN_RST, pidc_pkg::OUT_MAX_RST};
	longint integral_acc = 0;
	longint last_err = 0;

	logic [31:0] drive_expected_q [$];
	logic [31:0] drive_want;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;

	pid_controller_clamped i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] pid_next_drive(input logic [15:0] s);
		longint err, ts, diff, rate, total, lo, hi;
		err = longint'($signed(ctl_cfg.setpoint)) - longint'($signed(s));
		ts = longint'(ctl_cfg.time_step);
		integral_acc = integral_acc + err * ts;
		if (integral_acc > INTEG_MAX) integral_acc = INTEG_MAX;
		if (integral_acc < INTEG_MIN) integral_acc = INTEG_MIN;
		rate = 0;
		if (ts != 0) begin
			diff = err - last_err;
			rate = (diff <<< 24) / ts;
		end
		total = longint'($signed(ctl_cfg.gain_p)) * err
			+ ((longint'($signed(ctl_cfg.gain_i)) * integral_acc) >>> 16)
			+ ((longint'($signed(ctl_cfg.gain_d)) * rate) >>> 8);
		lo = longint'($signed(ctl_cfg.out_min));
		hi = longint'($signed(ctl_cfg.out_max));
		if (total < lo) total = lo;
		if (total > hi) total = hi;
		last_err = err;
		return total[31:0];
	endfunction

	function automatic logic [31:0] rand_q88();
		logic [15:0] v;
		case ($urandom_range(5))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = 16'($urandom);
			default: v = 16'($urandom_range(1023)) - 16'd512;
		endcase
		return {16'($urandom), v};
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return ctl_cfg.setpoint + 16'($urandom_range(63)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			pidc_pkg::REG_GAIN_P:    ctl_cfg.gain_p = val[15:0];
			pidc_pkg::REG_GAIN_I:    ctl_cfg.gain_i = val[15:0];
			pidc_pkg::REG_GAIN_D:    ctl_cfg.gain_d = val[15:0];
			pidc_pkg::REG_TIME_STEP: ctl_cfg.time_step = val[15:0];
			pidc_pkg::REG_SETPOINT:  ctl_cfg.setpoint = val[15:0];
			pidc_pkg::REG_OUT_MIN:   ctl_cfg.out_min = val;
			pidc_pkg::REG_OUT_MAX:   ctl_cfg.out_max = val;
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// hold input until every expected drive value has been transferred
	task automatic settle();
		sample_valid <= 1'b0;
		while (drive_expected_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_random();
		logic [31:0] lo, hi, ts;
		int unsigned m;
		case ($urandom_range(7))
			0: ts = 32'h0;
			1: ts = 32'hFFFF;
			2: ts = 32'($urandom_range(16, 1));
			default: ts = $urandom;
		endcase
		case ($urandom_range(3))
			0: begin
				lo = 32'h8000_0000;
				hi = 32'h7FFF_FFFF;
			end
			1: begin
				lo = $urandom;
				hi = $urandom;
			end
			2: begin
				m = $urandom_range(32'h00FF_FFFF);
				lo = 32'd0 - m;
				hi = m;
			end
			default: begin
				lo = 32'd0 - $urandom_range(32'h7FFF_FFFF);
				hi = $urandom_range(32'h7FFF_FFFF);
			end
		endcase
		write_reg(pidc_pkg::REG_GAIN_P, rand_q88());
		write_reg(pidc_pkg::REG_GAIN_I, rand_q88());
		write_reg(pidc_pkg::REG_GAIN_D, rand_q88());
		write_reg(pidc_pkg::REG_TIME_STEP, {16'($urandom), ts[15:0]});
		write_reg(pidc_pkg::REG_SETPOINT, rand_q88());
		write_reg(pidc_pkg::REG_OUT_MIN, lo);
		write_reg(pidc_pkg::REG_OUT_MAX, hi);
	endtask

	task automatic put_sample(input logic [15:0] s, input bit typed, input logic [31:0] want);
		int gap;
		logic [31:0] guess;
		gap = idle_on ? $urandom_range(6) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!(sample_valid && !sample_stall));
		guess = pid_next_drive(s);
		drive_expected_q.push_back(typed ? want : guess);
	endtask

	initial begin
		int n;
		drive_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				n = idle_on ? $urandom_range(6) : 0;
			end
			if (n > 0) begin
				drive_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			drive_stall <= 1'b0;
			do @(posedge clk); while (!(drive_valid && !drive_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && drive_valid && !drive_stall) begin
			if (drive_expected_q.size() == 0) begin
				$display("%t drive transfer with nothing expected: expected none, actual %h",
					$time, drive);
				mismatches++;
			end else begin
				drive_want = drive_expected_q.pop_front();
				if (drive !== drive_want) begin
					$display("%t drive mismatch: expected %h, actual %h",
						$time, drive_want, drive);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (drive_valid && !drive_stall) || wr_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%t no transfer for %0d cycles", $time, quiet_cycles);
				$display("testbench NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit up;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = pidc_pkg::REG_GAIN_P;
		wr_data = 32'h0;
		sample_valid = 1'b0;
		sample = 16'h0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].act == DO_WRITE) begin
				settle();
				write_reg(plan[k].idx, plan[k].val);
			end else begin
				put_sample(plan[k].val[15:0], plan[k].typed, plan[k].want);
			end
		end

		for (int ph = 0; ph < 12; ph++) begin
			settle();
			program_random();
			idle_on = (ph % 4 != 1);
			if (ph == 3) hold_req = 1'b1;
			repeat (66) put_sample(rand_sample(), 1'b0, 32'h0);
		end

		// push the integral hard one way, then reverse the error
		settle();
		idle_on = 1'b0;
		up = (integral_acc >= 0);
		write_reg(pidc_pkg::REG_GAIN_P, 32'h0);
		write_reg(pidc_pkg::REG_GAIN_I, 32'h1);
		write_reg(pidc_pkg::REG_GAIN_D, 32'h0);
		write_reg(pidc_pkg::REG_TIME_STEP, 32'hFFFF);
		write_reg(pidc_pkg::REG_SETPOINT, up ? 32'h7FFF : 32'h8000);
		write_reg(pidc_pkg::REG_OUT_MIN, 32'h8000_0000);
		write_reg(pidc_pkg::REG_OUT_MAX, 32'h7FFF_FFFF);
		repeat (30) put_sample(up ? 16'h8000 : 16'h7FFF, 1'b0, 32'h0);
		settle();
		write_reg(pidc_pkg::REG_SETPOINT, up ? 32'h8000 : 32'h7FFF);
		repeat (4) put_sample(up ? 16'h7FFF : 16'h8000, 1'b0, 32'h0);

		settle();
		idle_on = 1'b1;
		program_random();
		repeat (20) put_sample(rand_sample(), 1'b0, 32'h0);

		settle();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && drive_expected_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
